/* src/ume_pkg.sv */
// Shared types, constants and helper functions of the ustar member extractor.
package ume_pkg;

  localparam int PATH_BYTES_DEF  = 256;
  localparam int LENGTH_BITS_DEF = 29;

  localparam int CFG_W      = 29;
  localparam int BLOCK      = 512;
  localparam int NAME_LEN   = 100;
  localparam int PREFIX_LEN = 155;
  localparam int SIZE_W     = 36;
  localparam int CHECK_W    = 24;
  localparam int SUM_W      = 17;
  localparam int FULL_W     = 9;
  localparam int BPOS_W     = 9;
  localparam int NAME_AW    = 7;
  localparam int PREFIX_AW  = 8;

  localparam int OFS_SIZE   = 124;
  localparam int SIZE_BYTES = 12;
  localparam int OFS_CHK    = 148;
  localparam int CHK_BYTES  = 8;
  localparam int OFS_TYPE   = 156;
  localparam int OFS_MAGIC  = 257;
  localparam int MAGIC_LEN  = 5;
  localparam int OFS_PREFIX = 345;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;

  typedef enum logic [2:0] {
    ST_RUN       = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NOT_USTAR = 3'd3,
    ST_BAD_SUM   = 3'd4,
    ST_BAD_SIZE  = 3'd5,
    ST_TRUNC     = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE, PH_LOAD, PH_HEADER, PH_DATA, PH_SKIP, PH_DONE, PH_FIN, PH_CMP, PH_PAD
  } phase_e;

  typedef enum logic [3:0] {
    C_IDLE, C_WS_CHK, C_WS_RD1, C_WS_RD2, C_FS_CHK, C_FS_RD1, C_FS_RD2,
    C_LEN, C_CMP_RD, C_CMP_CHK
  } cmp_state_e;

  typedef enum logic [1:0] {
    FS_PRE, FS_NAME, FS_SLASH
  } fsel_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_in;
    logic       path_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       final_res;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] archive_length;
  } cfg_word_t;

  typedef struct packed {
    logic                 start;
    logic                 wovf;
    logic [PREFIX_AW-1:0] plen;
    logic [NAME_AW-1:0]   nlen;
  } cmp_req_t;

  typedef struct packed {
    logic done;
    logic match;
  } cmp_rsp_t;

  typedef struct packed {
    logic [2:0] flags;  // bit0 digit seen, bit1 trailer seen, bit2 invalid
    logic       shift;
  } oct_t;

  // Advance one octal field by one character.
  function automatic oct_t octal_step(input logic [2:0] f, input logic [7:0] c);
    oct_t r;
    r.flags = f;
    r.shift = 1'b0;
    if (!f[2]) begin
      if (c >= CHAR_ZERO && c <= CHAR_SEVEN) begin
        if (f[1]) begin
          r.flags[2] = 1'b1;
        end else begin
          r.shift    = 1'b1;
          r.flags[0] = 1'b1;
        end
      end else if (c == CHAR_SPACE || c == CHAR_NUL) begin
        if (f[0]) r.flags[1] = 1'b1;
      end else begin
        r.flags[2] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic octal_ok(input logic [2:0] f);
    return (f == 3'd1) || (f == 3'd3);
  endfunction

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h75;
      3'd1:    ch = 8'h73;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h61;
      3'd4:    ch = 8'h72;
      default: ch = CHAR_NUL;
    endcase
    return ch;
  endfunction

endpackage

/* src/ume_stream_if.sv */
// Valid/ready channel interface carrying one payload word.
interface ume_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/ustar_member_extractor_top.sv */
// Top level of the ustar member extractor: header walk, checks and data stream.
//
//  channel | dir | word        | fields
//  cfg_i   | in  | cfg_word_t  | archive_length
//  in_i    | in  | in_word_t   | mode, byte_in, path_end
//  out_o   | out | out_word_t  | file_byte, byte_valid, status, final_res
//
// Path, data, skipped and header bytes are taken as input while no check or compare runs.
// After the last header byte come the header checks, then the path compare sequencer,
// which strips leading "./" pairs and compares the path byte by byte, or the padding
// check of a skipped member; no input word is taken until these are done.
// Reset clears all control state; no clearing pass is run on the path stores.
// A stalled result is held in the output register; the next word is taken once it
// leaves or in the cycle it is taken.
module ustar_member_extractor_top #(
  parameter int PATH_BYTES  = ume_pkg::PATH_BYTES_DEF,
  parameter int LENGTH_BITS = ume_pkg::LENGTH_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ume_stream_if.sink   cfg_i,
  ume_stream_if.sink   in_i,
  ume_stream_if.source out_o
);

  localparam int AW = $clog2(PATH_BYTES);
  localparam int LW = $clog2(PATH_BYTES + 1);
  localparam int LB = LENGTH_BITS;
  localparam int PW = ume_pkg::SIZE_W + 1;
  localparam int BW = ume_pkg::BPOS_W;

  ume_pkg::phase_e    phase_q, phase_d;
  ume_pkg::out_word_t out_q, out_d;
  ume_pkg::in_word_t  iw;
  ume_pkg::cmp_req_t  cmp_req;
  ume_pkg::cmp_rsp_t  cmp_rsp;
  ume_pkg::oct_t      oct_sz, oct_ck;

  logic                   out_vld_q, out_vld_d;
  logic [LB-1:0]          alen_q, apos_q, apos_d, rem_q, rem_d, rem_now;
  logic [LW-1:0]          wlen_q, wlen_d, wl_eff;
  logic                   wovf_q, wovf_d;
  logic [BW-1:0]          bpos_q, bpos_d;
  logic [ume_pkg::SUM_W-1:0]   bsum_q, bsum_d;
  logic [ume_pkg::SIZE_W-1:0]  size_q, size_d, left_q, left_d;
  logic [ume_pkg::CHECK_W-1:0] chk_q, chk_d;
  logic [5:0]             oflg_q, oflg_d;
  logic [1:0]             hflg_q, hflg_d;  // bit0 nonzero byte seen, bit1 bad magic
  logic [7:0]             type_q, type_d;
  logic [ume_pkg::NAME_AW-1:0]   nlen_q, nlen_d;
  logic [ume_pkg::PREFIX_AW-1:0] plen_q, plen_d;
  logic                   ndone_q, ndone_d, pdone_q, pdone_d;
  logic                   in_acc, busy, start_hdr, fin_en;
  ume_pkg::status_e       fin_st;
  logic [PW-1:0]          padded, rem_ext;
  logic [7:0]             c;

  logic          wr_we, nm_we, pf_we;
  logic [AW-1:0] wr_raddr;
  logic [7:0]    wr_rdata, nm_rdata, pf_rdata;
  logic [ume_pkg::NAME_AW-1:0]   nm_raddr;
  logic [ume_pkg::PREFIX_AW-1:0] pf_raddr;

  assign iw     = in_i.data;
  assign c      = iw.byte_in;
  assign busy   = (phase_q == ume_pkg::PH_FIN) || (phase_q == ume_pkg::PH_CMP) ||
                  (phase_q == ume_pkg::PH_PAD);
  // Take a word only when no check or compare runs and the result register is free or drains this cycle.
  assign in_i.ready  = !busy && (!out_vld_q || out_o.ready);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // A path byte after a finished path or a scan starts a new path.
  assign wl_eff = (phase_q == ume_pkg::PH_LOAD) ? wlen_q : '0;

  assign wr_we = in_acc && !iw.mode && (wl_eff < LW'(PATH_BYTES));
  assign nm_we = in_acc && iw.mode && (phase_q == ume_pkg::PH_HEADER) &&
                 (bpos_q < BW'(ume_pkg::NAME_LEN));
  assign pf_we = in_acc && iw.mode && (phase_q == ume_pkg::PH_HEADER) &&
                 (bpos_q >= BW'(ume_pkg::OFS_PREFIX)) &&
                 (bpos_q < BW'(ume_pkg::OFS_PREFIX + ume_pkg::PREFIX_LEN));

  ume_ram #(.WIDTH(8), .DEPTH(PATH_BYTES)) u_wanted_ram (
    .clk_i   (clk_i),
    .we_i    (wr_we),
    .waddr_i (wl_eff[AW-1:0]),
    .wdata_i (c),
    .raddr_i (wr_raddr),
    .rdata_o (wr_rdata)
  );

  ume_ram #(.WIDTH(8), .DEPTH(ume_pkg::NAME_LEN)) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (nm_we),
    .waddr_i (bpos_q[ume_pkg::NAME_AW-1:0]),
    .wdata_i (c),
    .raddr_i (nm_raddr),
    .rdata_o (nm_rdata)
  );

  ume_ram #(.WIDTH(8), .DEPTH(ume_pkg::PREFIX_LEN)) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (pf_we),
    .waddr_i (ume_pkg::PREFIX_AW'(bpos_q - BW'(ume_pkg::OFS_PREFIX))),
    .wdata_i (c),
    .raddr_i (pf_raddr),
    .rdata_o (pf_rdata)
  );

  ume_path_cmp #(.PATH_BYTES(PATH_BYTES)) u_path_cmp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (cmp_req),
    .wlen_i    (wlen_q),
    .rsp_o     (cmp_rsp),
    .wr_addr_o (wr_raddr),
    .wr_data_i (wr_rdata),
    .nm_addr_o (nm_raddr),
    .nm_data_i (nm_rdata),
    .pf_addr_o (pf_raddr),
    .pf_data_i (pf_rdata)
  );

  assign oct_sz  = ume_pkg::octal_step(oflg_q[2:0], c);
  assign oct_ck  = ume_pkg::octal_step(oflg_q[5:3], c);
  assign rem_now = (alen_q > apos_q) ? (alen_q - apos_q) : '0;
  assign rem_ext = PW'(rem_q);
  // Round the member size up to whole blocks.
  assign padded  = (PW'(size_q) + PW'(ume_pkg::BLOCK - 1)) & ~PW'(ume_pkg::BLOCK - 1);

  always_comb begin
    phase_d   = phase_q;
    out_vld_d = out_vld_q && !out_o.ready;
    out_d     = out_q;
    apos_d    = apos_q;
    rem_d     = rem_q;
    wlen_d    = wlen_q;
    wovf_d    = wovf_q;
    bpos_d    = bpos_q;
    bsum_d    = bsum_q;
    size_d    = size_q;
    left_d    = left_q;
    chk_d     = chk_q;
    oflg_d    = oflg_q;
    hflg_d    = hflg_q;
    type_d    = type_q;
    nlen_d    = nlen_q;
    plen_d    = plen_q;
    ndone_d   = ndone_q;
    pdone_d   = pdone_q;
    start_hdr = 1'b0;
    fin_en    = 1'b0;
    fin_st    = ume_pkg::ST_NOT_FOUND;
    cmp_req.start = 1'b0;
    cmp_req.wovf  = wovf_q;
    cmp_req.plen  = plen_q;
    cmp_req.nlen  = nlen_q;

    unique case (phase_q)
      ume_pkg::PH_FIN: begin
        // Header checks in priority order.
        rem_d = rem_now;
        if (!hflg_q[0]) begin
          fin_en = 1'b1;
          fin_st = ume_pkg::ST_NOT_FOUND;
        end else if (hflg_q[1]) begin
          fin_en = 1'b1;
          fin_st = ume_pkg::ST_NOT_USTAR;
        end else if (!ume_pkg::octal_ok(oflg_q[5:3]) ||
                     chk_q != ume_pkg::CHECK_W'(bsum_q)) begin
          fin_en = 1'b1;
          fin_st = ume_pkg::ST_BAD_SUM;
        end else if (!ume_pkg::octal_ok(oflg_q[2:0])) begin
          fin_en = 1'b1;
          fin_st = ume_pkg::ST_BAD_SIZE;
        end else if (PW'(size_q) > PW'(rem_now)) begin
          fin_en = 1'b1;
          fin_st = ume_pkg::ST_TRUNC;
        end else if (type_q == ume_pkg::CHAR_ZERO || type_q == ume_pkg::CHAR_NUL) begin
          cmp_req.start = 1'b1;
          phase_d       = ume_pkg::PH_CMP;
        end else begin
          phase_d = ume_pkg::PH_PAD;
        end
      end
      ume_pkg::PH_CMP: begin
        if (cmp_rsp.done) begin
          if (cmp_rsp.match) begin
            if (size_q == '0) begin
              fin_en = 1'b1;
              fin_st = ume_pkg::ST_FOUND;
            end else begin
              left_d  = size_q;
              phase_d = ume_pkg::PH_DATA;
            end
          end else begin
            phase_d = ume_pkg::PH_PAD;
          end
        end
      end
      ume_pkg::PH_PAD: begin
        // End the walk when no whole block follows the skipped member.
        if (padded > rem_ext || (rem_ext - padded) < PW'(ume_pkg::BLOCK)) begin
          fin_en = 1'b1;
          fin_st = ume_pkg::ST_NOT_FOUND;
        end else if (padded == '0) begin
          start_hdr = 1'b1;
        end else begin
          left_d  = padded[ume_pkg::SIZE_W-1:0];
          phase_d = ume_pkg::PH_SKIP;
        end
      end
      default: begin
        if (in_acc && !iw.mode) begin
          if (phase_q != ume_pkg::PH_LOAD) begin
            wovf_d  = 1'b0;
            phase_d = ume_pkg::PH_LOAD;
          end
          if (wl_eff < LW'(PATH_BYTES)) wlen_d = wl_eff + LW'(1);
          else wovf_d = 1'b1;
          if (iw.path_end) begin
            apos_d    = '0;
            left_d    = '0;
            start_hdr = 1'b1;
            if (alen_q < LB'(ume_pkg::BLOCK)) begin
              fin_en = 1'b1;
              fin_st = ume_pkg::ST_NOT_FOUND;
            end
          end
        end else if (in_acc) begin
          unique case (phase_q)
            ume_pkg::PH_HEADER: begin
              if (c != ume_pkg::CHAR_NUL) hflg_d[0] = 1'b1;
              // Checksum field counts as spaces.
              if (bpos_q >= BW'(ume_pkg::OFS_CHK) &&
                  bpos_q < BW'(ume_pkg::OFS_CHK + ume_pkg::CHK_BYTES)) begin
                bsum_d = bsum_q + ume_pkg::SUM_W'(ume_pkg::CHAR_SPACE);
                oflg_d[5:3] = oct_ck.flags;
                if (oct_ck.shift) begin
                  chk_d = {chk_q[ume_pkg::CHECK_W-4:0], 3'b000} +
                          ume_pkg::CHECK_W'(c[2:0]);
                end
              end else begin
                bsum_d = bsum_q + ume_pkg::SUM_W'(c);
              end
              if (bpos_q < BW'(ume_pkg::NAME_LEN) && !ndone_q) begin
                if (c == ume_pkg::CHAR_NUL) ndone_d = 1'b1;
                else nlen_d = nlen_q + 1'b1;
              end
              if (bpos_q >= BW'(ume_pkg::OFS_SIZE) &&
                  bpos_q < BW'(ume_pkg::OFS_SIZE + ume_pkg::SIZE_BYTES)) begin
                oflg_d[2:0] = oct_sz.flags;
                if (oct_sz.shift) begin
                  size_d = {size_q[ume_pkg::SIZE_W-4:0], 3'b000} +
                           ume_pkg::SIZE_W'(c[2:0]);
                end
              end
              if (bpos_q == BW'(ume_pkg::OFS_TYPE)) type_d = c;
              if (bpos_q >= BW'(ume_pkg::OFS_MAGIC) &&
                  bpos_q < BW'(ume_pkg::OFS_MAGIC + ume_pkg::MAGIC_LEN)) begin
                if (c != ume_pkg::magic_char(3'(bpos_q - BW'(ume_pkg::OFS_MAGIC))))
                  hflg_d[1] = 1'b1;
              end
              if (pf_we && !pdone_q) begin
                if (c == ume_pkg::CHAR_NUL) pdone_d = 1'b1;
                else plen_d = plen_q + 1'b1;
              end
              apos_d = apos_q + LB'(1);
              if (bpos_q == BW'(ume_pkg::BLOCK - 1)) phase_d = ume_pkg::PH_FIN;
              else bpos_d = bpos_q + BW'(1);
            end
            ume_pkg::PH_SKIP: begin
              apos_d = apos_q + LB'(1);
              left_d = left_q - 1'b1;
              if (left_q == ume_pkg::SIZE_W'(1)) start_hdr = 1'b1;
            end
            ume_pkg::PH_DATA: begin
              apos_d           = apos_q + LB'(1);
              left_d           = left_q - 1'b1;
              out_vld_d        = 1'b1;
              out_d.file_byte  = c;
              out_d.byte_valid = 1'b1;
              if (left_q == ume_pkg::SIZE_W'(1)) begin
                out_d.status    = ume_pkg::ST_FOUND;
                out_d.final_res = 1'b1;
                phase_d         = ume_pkg::PH_DONE;
              end else begin
                out_d.status    = ume_pkg::ST_RUN;
                out_d.final_res = 1'b0;
              end
            end
            default: ;  // drop archive bytes outside a scan
          endcase
        end
      end
    endcase

    if (start_hdr) begin
      bpos_d  = '0;
      bsum_d  = '0;
      size_d  = '0;
      chk_d   = '0;
      oflg_d  = '0;
      hflg_d  = '0;
      type_d  = '0;
      nlen_d  = '0;
      plen_d  = '0;
      ndone_d = 1'b0;
      pdone_d = 1'b0;
      phase_d = ume_pkg::PH_HEADER;
    end
    if (fin_en) begin
      out_vld_d        = 1'b1;
      out_d.file_byte  = '0;
      out_d.byte_valid = 1'b0;
      out_d.status     = fin_st;
      out_d.final_res  = 1'b1;
      phase_d          = ume_pkg::PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ume_pkg::PH_IDLE;
      out_vld_q <= 1'b0;
      alen_q    <= '0;
      apos_q    <= '0;
      rem_q     <= '0;
      wlen_q    <= '0;
      wovf_q    <= 1'b0;
      bpos_q    <= '0;
      bsum_q    <= '0;
      size_q    <= '0;
      left_q    <= '0;
      chk_q     <= '0;
      oflg_q    <= '0;
      hflg_q    <= '0;
      type_q    <= '0;
      nlen_q    <= '0;
      plen_q    <= '0;
      ndone_q   <= 1'b0;
      pdone_q   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      out_vld_q <= out_vld_d;
      if (cfg_i.valid) alen_q <= LB'(cfg_i.data.archive_length);
      apos_q    <= apos_d;
      rem_q     <= rem_d;
      wlen_q    <= wlen_d;
      wovf_q    <= wovf_d;
      bpos_q    <= bpos_d;
      bsum_q    <= bsum_d;
      size_q    <= size_d;
      left_q    <= left_d;
      chk_q     <= chk_d;
      oflg_q    <= oflg_d;
      hflg_q    <= hflg_d;
      type_q    <= type_d;
      nlen_q    <= nlen_d;
      plen_q    <= plen_d;
      ndone_q   <= ndone_d;
      pdone_q   <= pdone_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

/* src/ume_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module ume_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ume_path_cmp.sv */
// Path compare sequencer: strips leading "./" pairs and compares byte by byte.
module ume_path_cmp #(
  parameter int PATH_BYTES = ume_pkg::PATH_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ume_pkg::cmp_req_t               req_i,
  input  logic [$clog2(PATH_BYTES+1)-1:0] wlen_i,
  output ume_pkg::cmp_rsp_t               rsp_o,
  output logic [$clog2(PATH_BYTES)-1:0]   wr_addr_o,
  input  logic [7:0]                      wr_data_i,
  output logic [ume_pkg::NAME_AW-1:0]     nm_addr_o,
  input  logic [7:0]                      nm_data_i,
  output logic [ume_pkg::PREFIX_AW-1:0]   pf_addr_o,
  input  logic [7:0]                      pf_data_i
);

  localparam int AW = $clog2(PATH_BYTES);
  localparam int LW = $clog2(PATH_BYTES + 1);
  localparam int CW = ((LW > ume_pkg::FULL_W) ? LW : ume_pkg::FULL_W) + 1;
  localparam int FW = ume_pkg::FULL_W;

  ume_pkg::cmp_state_e st_q, st_d;
  ume_pkg::fsel_e      sel_q, sel_d;
  logic [LW-1:0] ws_q, ws_d, wlen_q, wlen_d, i_q, i_d, n_q, n_d;
  logic [FW-1:0] fs_q, fs_d, fidx, fl, nm_off;
  logic [7:0]    d0_q, d0_d, full_byte;
  logic          wovf_q, wovf_d;
  logic [ume_pkg::PREFIX_AW-1:0] plen_q, plen_d;
  logic [ume_pkg::NAME_AW-1:0]   nlen_q, nlen_d;

  assign fl = FW'(plen_q) + FW'(plen_q != '0) + FW'(nlen_q);

  always_comb begin
    full_byte = pf_data_i;
    unique case (sel_q)
      ume_pkg::FS_NAME:  full_byte = nm_data_i;
      ume_pkg::FS_SLASH: full_byte = ume_pkg::CHAR_SLASH;
      default:           full_byte = pf_data_i;
    endcase
  end

  always_comb begin
    st_d   = st_q;
    ws_d   = ws_q;
    fs_d   = fs_q;
    i_d    = i_q;
    n_d    = n_q;
    d0_d   = d0_q;
    wlen_d = wlen_q;
    wovf_d = wovf_q;
    plen_d = plen_q;
    nlen_d = nlen_q;
    rsp_o  = '0;
    wr_addr_o = ws_q[AW-1:0];
    fidx   = fs_q;
    unique case (st_q)
      ume_pkg::C_IDLE: begin
        if (req_i.start) begin
          ws_d   = '0;
          fs_d   = '0;
          wlen_d = wlen_i;
          wovf_d = req_i.wovf;
          plen_d = req_i.plen;
          nlen_d = req_i.nlen;
          st_d   = ume_pkg::C_WS_CHK;
        end
      end
      ume_pkg::C_WS_CHK: begin
        if ((CW'(ws_q) + CW'(2)) < CW'(wlen_q)) st_d = ume_pkg::C_WS_RD1;
        else st_d = ume_pkg::C_FS_CHK;
      end
      ume_pkg::C_WS_RD1: begin
        d0_d      = wr_data_i;
        wr_addr_o = AW'(ws_q + LW'(1));
        st_d      = ume_pkg::C_WS_RD2;
      end
      ume_pkg::C_WS_RD2: begin
        if (d0_q == ume_pkg::CHAR_DOT && wr_data_i == ume_pkg::CHAR_SLASH) begin
          ws_d = ws_q + LW'(2);
          st_d = ume_pkg::C_WS_CHK;
        end else begin
          st_d = ume_pkg::C_FS_CHK;
        end
      end
      ume_pkg::C_FS_CHK: begin
        if ((CW'(fs_q) + CW'(2)) < CW'(fl)) st_d = ume_pkg::C_FS_RD1;
        else st_d = ume_pkg::C_LEN;
      end
      ume_pkg::C_FS_RD1: begin
        d0_d = full_byte;
        fidx = fs_q + FW'(1);
        st_d = ume_pkg::C_FS_RD2;
      end
      ume_pkg::C_FS_RD2: begin
        if (d0_q == ume_pkg::CHAR_DOT && full_byte == ume_pkg::CHAR_SLASH) begin
          fs_d = fs_q + FW'(2);
          st_d = ume_pkg::C_FS_CHK;
        end else begin
          st_d = ume_pkg::C_LEN;
        end
      end
      ume_pkg::C_LEN: begin
        if (wovf_q || CW'(fl - fs_q) != CW'(wlen_q - ws_q)) begin
          rsp_o.done = 1'b1;
          st_d       = ume_pkg::C_IDLE;
        end else if (wlen_q == ws_q) begin
          rsp_o.done  = 1'b1;
          rsp_o.match = 1'b1;
          st_d        = ume_pkg::C_IDLE;
        end else begin
          n_d  = wlen_q - ws_q;
          i_d  = '0;
          st_d = ume_pkg::C_CMP_RD;
        end
      end
      ume_pkg::C_CMP_RD: begin
        wr_addr_o = AW'(ws_q + i_q);
        fidx      = FW'(CW'(fs_q) + CW'(i_q));
        st_d      = ume_pkg::C_CMP_CHK;
      end
      ume_pkg::C_CMP_CHK: begin
        if (wr_data_i != full_byte) begin
          rsp_o.done = 1'b1;
          st_d       = ume_pkg::C_IDLE;
        end else if (i_q + LW'(1) == n_q) begin
          rsp_o.done  = 1'b1;
          rsp_o.match = 1'b1;
          st_d        = ume_pkg::C_IDLE;
        end else begin
          i_d  = i_q + LW'(1);
          st_d = ume_pkg::C_CMP_RD;
        end
      end
      default: st_d = ume_pkg::C_IDLE;
    endcase
  end

  // Map a full-path index onto prefix, separator or name.
  always_comb begin
    nm_off    = fidx - FW'(plen_q) - FW'(plen_q != '0);
    pf_addr_o = fidx[ume_pkg::PREFIX_AW-1:0];
    nm_addr_o = nm_off[ume_pkg::NAME_AW-1:0];
    if (fidx < FW'(plen_q)) sel_d = ume_pkg::FS_PRE;
    else if (plen_q != '0 && fidx == FW'(plen_q)) sel_d = ume_pkg::FS_SLASH;
    else sel_d = ume_pkg::FS_NAME;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ume_pkg::C_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q  <= sel_d;
    ws_q   <= ws_d;
    fs_q   <= fs_d;
    i_q    <= i_d;
    n_q    <= n_d;
    d0_q   <= d0_d;
    wlen_q <= wlen_d;
    wovf_q <= wovf_d;
    plen_q <= plen_d;
    nlen_q <= nlen_d;
  end

endmodule

/* src/ume_checker.sv */
// Port-level assertions for the ustar member extractor, bound to its top level.
module ume_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_mode_i,
  input logic       in_path_end_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_byte_valid_i,
  input logic [2:0] out_status_i,
  input logic       out_final_i
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(out_status_i) && $stable(out_final_i) && $stable(out_byte_valid_i))
    else $error("result word changed while stalled");

  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("input taken with no room for its result");

  a_path_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_mode_i && !in_path_end_i |=> !out_valid_i)
    else $error("path byte produced a result");

  a_nodata_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_byte_valid_i |-> out_final_i && out_status_i != 3'd0)
    else $error("result without data is not a final status");

endmodule

bind ustar_member_extractor_top ume_checker u_ume_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_mode_i        (in_i.data.mode),
  .in_path_end_i    (in_i.data.path_end),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_byte_i       (out_o.data.file_byte),
  .out_byte_valid_i (out_o.data.byte_valid),
  .out_status_i     (out_o.data.status),
  .out_final_i      (out_o.data.final_res)
);
